/* design/dse_pkg.sv */
// shared constants, types and state codes of the statistics engine
package dse_pkg;

  localparam int MAX_ITEMS  = 32;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int SUM_W  = DATA_WIDTH + CNT_W;
  localparam int DIVD_W = SUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DIVD_W + 1);
  localparam int AVG_W  = 24;
  localparam int OCC_W  = 6;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic {
    KIND_LOAD,
    KIND_DROP
  } item_kind_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] sample;
    logic                  last;
    item_kind_t            kind;
    logic [IDX_W-1:0]      idx;
  } queue_item_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_FINISH
  } back_state_t;

endpackage

/* design/dse_front.sv */
// front end: accepts items, classifies them against capacity, queues them
module dse_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [dse_pkg::DATA_WIDTH-1:0]      sample,
  input  logic                                last_item,
  output logic                                busy,
  input  logic                                pop,
  output logic                                head_valid,
  output dse_pkg::queue_item_t                head
);

  dse_pkg::queue_item_t              q [dse_pkg::QDEPTH];
  logic [dse_pkg::QPTR_W-1:0]        wr_ptr;
  logic [dse_pkg::QPTR_W-1:0]        rd_ptr;
  logic [dse_pkg::QCNT_W-1:0]        qcnt;
  logic [dse_pkg::CNT_W-1:0]         fill;
  logic [dse_pkg::CNT_W-1:0]         fill_next;
  logic                              accept;
  logic                              do_pop;
  dse_pkg::queue_item_t              entry;

  assign busy       = (qcnt == dse_pkg::QCNT_W'(dse_pkg::QDEPTH));
  assign head_valid = (qcnt != '0);
  assign head       = q[rd_ptr];
  assign accept     = start && !busy;
  assign do_pop     = pop && head_valid;

  always_comb begin
    entry.sample = sample;
    entry.last   = last_item;
    entry.idx    = fill[dse_pkg::IDX_W-1:0];
    if (fill == dse_pkg::CNT_W'(dse_pkg::MAX_ITEMS)) begin
      entry.kind = dse_pkg::KIND_DROP;
    end else begin
      entry.kind = dse_pkg::KIND_LOAD;
    end
    fill_next = fill;
    if (accept) begin
      if (last_item) begin
        fill_next = '0;
      end else if (entry.kind == dse_pkg::KIND_LOAD) begin
        fill_next = fill + dse_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcnt   <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (accept) begin
        wr_ptr <= wr_ptr + dse_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + dse_pkg::QPTR_W'(1);
      end
      if (accept && !do_pop) begin
        qcnt <= qcnt + dse_pkg::QCNT_W'(1);
      end else if (!accept && do_pop) begin
        qcnt <= qcnt - dse_pkg::QCNT_W'(1);
      end
    end
  end

  a_fill_clears_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_item |=> fill == '0)
    else $error("fill count not cleared after last item");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    fill <= dse_pkg::CNT_W'(dse_pkg::MAX_ITEMS))
    else $error("fill count beyond capacity");

endmodule

/* design/dse_div.sv */
// restoring divider, one quotient bit per cycle, for the fixed-point mean
module dse_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dse_pkg::DIVD_W-1:0]      dividend,
  input  logic [dse_pkg::CNT_W-1:0]       divisor,
  output logic                            done,
  output logic [dse_pkg::DIVD_W-1:0]      quotient
);

  logic [dse_pkg::DIVD_W-1:0]  acc;
  logic [dse_pkg::CNT_W-1:0]   rem;
  logic [dse_pkg::CNT_W-1:0]   dvs;
  logic [dse_pkg::STEP_W-1:0]  step;
  logic                        running;
  logic [dse_pkg::CNT_W:0]     shifted;
  logic [dse_pkg::CNT_W:0]     diff;
  logic                        ge;

  assign shifted  = {rem, acc[dse_pkg::DIVD_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = (shifted >= {1'b0, dvs});
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      acc <= {acc[dse_pkg::DIVD_W-2:0], ge};
      rem <= ge ? diff[dse_pkg::CNT_W-1:0] : shifted[dse_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + dse_pkg::STEP_W'(1);
        if (step == dse_pkg::STEP_W'(dse_pkg::DIVD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/dse_back.sv */
// back end: value store, running max/min/sum, pairwise mode search, result
module dse_back (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   head_valid,
  input  dse_pkg::queue_item_t                   head,
  output logic                                   pop,
  output logic                                   done,
  output logic signed [dse_pkg::DATA_WIDTH-1:0]  largest,
  output logic signed [dse_pkg::DATA_WIDTH-1:0]  smallest,
  output logic signed [dse_pkg::AVG_W-1:0]       average_fixed,
  output logic signed [dse_pkg::DATA_WIDTH-1:0]  most_frequent,
  output logic [dse_pkg::OCC_W-1:0]              mode_occurrences,
  output logic [dse_pkg::OCC_W-1:0]              set_size,
  output logic                                   capacity_exceeded
);

  dse_pkg::back_state_t                  state;
  dse_pkg::back_state_t                  state_next;

  logic [dse_pkg::DATA_WIDTH-1:0]        mem [dse_pkg::MAX_ITEMS];
  logic [dse_pkg::IDX_W-1:0]             addr_a;
  logic [dse_pkg::IDX_W-1:0]             addr_b;
  logic [dse_pkg::DATA_WIDTH-1:0]        rd_a;
  logic [dse_pkg::DATA_WIDTH-1:0]        rd_b;

  logic [dse_pkg::CNT_W-1:0]             count;
  logic signed [dse_pkg::DATA_WIDTH-1:0] rmax;
  logic signed [dse_pkg::DATA_WIDTH-1:0] rmin;
  logic signed [dse_pkg::SUM_W-1:0]      rsum;
  logic                                  ovf;
  logic signed [dse_pkg::DATA_WIDTH-1:0] s;

  logic [dse_pkg::IDX_W-1:0]             ii;
  logic [dse_pkg::IDX_W-1:0]             jj;
  logic [dse_pkg::IDX_W-1:0]             pi;
  logic                                  pv;
  logic                                  pend;
  logic                                  row_end;
  logic                                  scan_end;
  logic [dse_pkg::CNT_W-1:0]             later;
  logic [dse_pkg::CNT_W-1:0]             later_sum;
  logic [dse_pkg::CNT_W-1:0]             best_cnt;
  logic [dse_pkg::IDX_W-1:0]             best_idx;

  logic                                  div_start;
  logic                                  div_done;
  logic                                  div_flag;
  logic [dse_pkg::DIVD_W-1:0]            dividend;
  logic [dse_pkg::DIVD_W-1:0]            quotient;
  logic                                  sum_neg;
  logic [dse_pkg::SUM_W-1:0]             sum_mag;
  logic [dse_pkg::AVG_W-1:0]             q_ext;
  logic                                  finish;

  assign s        = $signed(head.sample);
  assign sum_neg  = rsum[dse_pkg::SUM_W-1];
  assign sum_mag  = sum_neg ? -rsum : rsum;
  assign dividend = dse_pkg::DIVD_W'(sum_mag) << dse_pkg::FRAC_BITS;
  assign q_ext    = dse_pkg::AVG_W'(quotient);
  assign row_end  = (dse_pkg::CNT_W'(jj) == count - dse_pkg::CNT_W'(1));
  assign scan_end = row_end && (dse_pkg::CNT_W'(ii) == count - dse_pkg::CNT_W'(2));
  assign later_sum = later + dse_pkg::CNT_W'(rd_a == rd_b);
  assign addr_a   = (state == dse_pkg::ST_SCAN) ? ii : best_idx;
  assign addr_b   = jj;
  assign finish   = (state == dse_pkg::ST_FINISH) && div_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dse_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      dse_pkg::ST_LOAD: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.last) begin
            state_next = dse_pkg::ST_START;
          end
        end
      end
      dse_pkg::ST_START: begin
        div_start = 1'b1;
        if (count == dse_pkg::CNT_W'(1)) begin
          state_next = dse_pkg::ST_FETCH;
        end else begin
          state_next = dse_pkg::ST_SCAN;
        end
      end
      dse_pkg::ST_SCAN: begin
        if (scan_end) begin
          state_next = dse_pkg::ST_DRAIN;
        end
      end
      dse_pkg::ST_DRAIN: begin
        state_next = dse_pkg::ST_FETCH;
      end
      dse_pkg::ST_FETCH: begin
        state_next = dse_pkg::ST_FINISH;
      end
      dse_pkg::ST_FINISH: begin
        if (div_flag) begin
          state_next = dse_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = dse_pkg::ST_LOAD;
      end
    endcase
  end

  // value store
  always_ff @(posedge clk) begin
    if (pop && head.kind == dse_pkg::KIND_LOAD) begin
      mem[head.idx] <= head.sample;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // running statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rmax  <= '0;
      rmin  <= '0;
      rsum  <= '0;
      ovf   <= 1'b0;
    end else if (finish) begin
      count <= '0;
      rmax  <= '0;
      rmin  <= '0;
      rsum  <= '0;
      ovf   <= 1'b0;
    end else if (pop) begin
      if (head.kind == dse_pkg::KIND_LOAD) begin
        if (count == '0) begin
          rmax <= s;
          rmin <= s;
        end else begin
          if (s > rmax) begin
            rmax <= s;
          end
          if (s < rmin) begin
            rmin <= s;
          end
        end
        rsum  <= rsum + dse_pkg::SUM_W'(s);
        count <= count + dse_pkg::CNT_W'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // pairwise mode search, one compare per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == dse_pkg::ST_SCAN);
    end
  end

  always_ff @(posedge clk) begin
    pend <= row_end;
    pi   <= ii;
    if (state == dse_pkg::ST_START) begin
      ii       <= '0;
      jj       <= dse_pkg::IDX_W'(1);
      later    <= '0;
      best_cnt <= '0;
      best_idx <= '0;
    end else begin
      if (state == dse_pkg::ST_SCAN) begin
        if (row_end) begin
          ii <= ii + dse_pkg::IDX_W'(1);
          jj <= ii + dse_pkg::IDX_W'(2);
        end else begin
          jj <= jj + dse_pkg::IDX_W'(1);
        end
      end
      if (pv) begin
        if (pend) begin
          later <= '0;
          if (later_sum > best_cnt) begin
            best_cnt <= later_sum;
            best_idx <= pi;
          end
        end else begin
          later <= later_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_flag <= 1'b0;
    end else if (div_start) begin
      div_flag <= 1'b0;
    end else if (div_done) begin
      div_flag <= 1'b1;
    end
  end

  dse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (count),
    .done     (div_done),
    .quotient (quotient)
  );

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      largest           <= rmax;
      smallest          <= rmin;
      average_fixed     <= sum_neg ? -q_ext : q_ext;
      most_frequent     <= $signed(rd_a);
      mode_occurrences  <= dse_pkg::OCC_W'(best_cnt + dse_pkg::CNT_W'(1));
      set_size          <= dse_pkg::OCC_W'(count);
      capacity_exceeded <= ovf;
    end
  end

  a_store_index: assert property (@(posedge clk) disable iff (rst)
    pop && head.kind == dse_pkg::KIND_LOAD |-> dse_pkg::CNT_W'(head.idx) == count)
    else $error("store index out of step with count");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    done |-> set_size != '0)
    else $error("result over an empty set");

  a_cleared_after_result: assert property (@(posedge clk) disable iff (rst)
    done |-> count == '0 && !ovf && rsum == '0)
    else $error("state not cleared after result");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (rst)
    state != dse_pkg::ST_LOAD |-> !pop)
    else $error("item taken during result computation");

endmodule

/* design/descriptive_stats_engine.sv */
// top level of the min/max/mean/mode statistics engine
// an item is queued at the accepting edge and, unless beyond capacity, stored from the queue head
// while the back end loads; done rises once the last item of an n-value set has left the queue
// and both the mode search (one store compare per cycle) and the divider (one quotient bit per
// cycle) have finished; busy rises only when the queue is full
// rst is synchronous and clears queue, counts, running statistics and flags; done cannot stall
module descriptive_stats_engine (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [dse_pkg::DATA_WIDTH-1:0]  sample,
  input  logic                                   last_item,
  output logic                                   done,
  output logic signed [dse_pkg::DATA_WIDTH-1:0]  largest,
  output logic signed [dse_pkg::DATA_WIDTH-1:0]  smallest,
  output logic signed [dse_pkg::AVG_W-1:0]       average_fixed,
  output logic signed [dse_pkg::DATA_WIDTH-1:0]  most_frequent,
  output logic [dse_pkg::OCC_W-1:0]              mode_occurrences,
  output logic [dse_pkg::OCC_W-1:0]              set_size,
  output logic                                   capacity_exceeded
);

  logic                  pop;
  logic                  head_valid;
  dse_pkg::queue_item_t  head;

  dse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .sample     (sample),
    .last_item  (last_item),
    .busy       (busy),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dse_back u_back (
    .clk               (clk),
    .rst               (rst),
    .head_valid        (head_valid),
    .head              (head),
    .pop               (pop),
    .done              (done),
    .largest           (largest),
    .smallest          (smallest),
    .average_fixed     (average_fixed),
    .most_frequent     (most_frequent),
    .mode_occurrences  (mode_occurrences),
    .set_size          (set_size),
    .capacity_exceeded (capacity_exceeded)
  );

endmodule
